[design/bdcc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdcc_pkg
// Shared sizes and register codes for the band dark centroid classifier.
// ----------------------------------------------------------------------------
package bdcc_pkg;

   localparam int MAX_ROWS       = 256;
   localparam int MAX_BAND_WIDTH = 16;
   localparam int MAX_BANDS      = 1024;

   // Largest number of dark pixels that one band accumulates.
   localparam int MAX_DARK = MAX_BAND_WIDTH * MAX_ROWS;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int ROW_END_W  = ROW_W + 1;
   localparam int BW_W       = 5;
   localparam int COL_W      = $clog2(MAX_BAND_WIDTH);
   localparam int BAND_W     = $clog2(MAX_BANDS);
   localparam int CNT_W      = $clog2(MAX_DARK + 1);
   localparam int SUM_W      = $clog2(MAX_DARK * (MAX_ROWS - 1) + 1);
   localparam int DIVCNT_W   = $clog2(SUM_W);
   localparam int CLASS_W    = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_THRESHOLD  = 2'd0,
      CSR_ROW_START  = 2'd1,
      CSR_ROW_END    = 2'd2,
      CSR_BAND_WIDTH = 2'd3
   } csr_index_type;

   localparam logic [PIX_W-1:0]     THRESHOLD_RESET  = 8'd107;
   localparam logic [ROW_W-1:0]     ROW_START_RESET  = 8'd12;
   localparam logic [ROW_END_W-1:0] ROW_END_RESET    = 9'd110;
   localparam logic [BW_W-1:0]      BAND_WIDTH_RESET = 5'd4;
   localparam logic [CLASS_W-1:0]   CLASS_MISSING    = 8'hFF;

endpackage : bdcc_pkg
`default_nettype wire

[design/band_dark_centroid_class_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// band_dark_centroid_class_unit
// Accumulates dark pixel rows per band of columns and classifies the band by
// its halved centroid row offset, using a shared bit-serial divider.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake           | Word
//   --------+-----------+---------------------+----------------------------------
//   req_    | in        | req_valid/req_stall | pixel, row_index, column_end, ...
//   rsp_    | out       | rsp_valid/rsp_stall | class_id, band_index
//   csr_    | in        | APB psel/penable    | four 32-bit registers at 4*i
//
// A pixel that does not close a band leaves the unit idle. A word that closes a
// band goes straight to the send state when the band has no usable line, and
// otherwise first to the restoring divider, one quotient bit per cycle over 20 bits.
// Reset is synchronous and returns registers to their defaults and the band to
// empty. The output register lets a new pixel in while a result waits, but a
// band result that finds the output register still full holds req_stall high.

module band_dark_centroid_class_unit (
   input  wire                               clock,
   input  wire                               reset,
   // pixel input
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [bdcc_pkg::PIX_W-1:0]        req_pixel,
   input  wire  [bdcc_pkg::ROW_W-1:0]        req_row_index,
   input  wire                               req_column_end,
   input  wire                               req_image_end,
   // class output
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic signed [bdcc_pkg::CLASS_W-1:0] rsp_class_id,
   output logic [bdcc_pkg::BAND_W-1:0]       rsp_band_index,
   // register port
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [bdcc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [bdcc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bdcc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import bdcc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEND
   } state_type;

   state_type               state_ff, state_in;

   logic [PIX_W-1:0]        threshold_ff;
   logic [ROW_W-1:0]        row_start_ff;
   logic [ROW_END_W-1:0]    row_end_ff;
   logic [BW_W-1:0]         band_width_ff;

   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    col_dark_ff, col_dark_in;
   logic                    missing_ff, missing_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [BAND_W-1:0]       band_ff, band_in;

   logic [SUM_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        divisor_ff, divisor_in;
   logic [DIVCNT_W-1:0]     step_ff, step_in;
   logic                    use_div_ff, use_div_in;
   logic [BAND_W-1:0]       pend_band_ff, pend_band_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0]      rsp_class_ff, rsp_class_in;
   logic [BAND_W-1:0]       rsp_band_ff, rsp_band_in;

   logic                    csr_write;
   csr_index_type           csr_index;

   logic                    accept;
   logic                    dark;
   logic                    col_dark_next;
   logic                    count_room;
   logic [SUM_W-1:0]        sum_next;
   logic [CNT_W-1:0]        count_next;
   logic                    col_close;
   logic                    missing_next;
   logic [BW_W-1:0]         width_eff;
   logic [BW_W-1:0]         col_inc;
   logic                    band_done;
   logic [BAND_W-1:0]       band_inc;

   logic [CNT_W:0]          rem_shift;
   logic [CNT_W:0]          rem_diff;
   logic                    rem_ge;

   logic                    out_free;
   logic [SUM_W-1:0]        avg_offset;
   logic [CLASS_W-1:0]      class_value;

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         CSR_THRESHOLD:  csr_prdata = CSR_DATA_W'(threshold_ff);
         CSR_ROW_START:  csr_prdata = CSR_DATA_W'(row_start_ff);
         CSR_ROW_END:    csr_prdata = CSR_DATA_W'(row_end_ff);
         CSR_BAND_WIDTH: csr_prdata = CSR_DATA_W'(band_width_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         row_start_ff  <= ROW_START_RESET;
         row_end_ff    <= ROW_END_RESET;
         band_width_ff <= BAND_WIDTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD:  threshold_ff  <= csr_pwdata[PIX_W-1:0];
            CSR_ROW_START:  row_start_ff  <= csr_pwdata[ROW_W-1:0];
            CSR_ROW_END:    row_end_ff    <= csr_pwdata[ROW_END_W-1:0];
            CSR_BAND_WIDTH: band_width_ff <= csr_pwdata[BW_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pixel accumulation
   // ------------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign dark = (req_row_index >= row_start_ff)
              && ({1'b0, req_row_index} < row_end_ff)
              && (req_pixel <= threshold_ff);
   assign col_dark_next = col_dark_ff || dark;

   // Past the limit, further dark pixels still mark the column but add nothing.
   assign count_room = (count_ff < CNT_W'(MAX_DARK));
   assign sum_next   = (dark && count_room) ? sum_ff + SUM_W'(req_row_index) : sum_ff;
   assign count_next = (dark && count_room) ? count_ff + CNT_W'(1) : count_ff;

   assign col_close    = req_column_end || req_image_end;
   assign missing_next = missing_ff || (col_close && !col_dark_next);

   always_comb begin
      priority if (band_width_ff == '0)
         width_eff = BW_W'(1);
      else if (band_width_ff > BW_W'(MAX_BAND_WIDTH))
         width_eff = BW_W'(MAX_BAND_WIDTH);
      else
         width_eff = band_width_ff;
   end

   assign col_inc   = BW_W'(col_ff) + BW_W'(1);
   assign band_done = col_close && (col_inc >= width_eff);
   assign band_inc  = (band_ff == BAND_W'(MAX_BANDS - 1)) ? '0 : band_ff + BAND_W'(1);

   // ------------------------------------------------------------------------
   // Shared restoring divider: one quotient bit per cycle
   // ------------------------------------------------------------------------
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});

   // Class from the quotient; a band without a division, or a centroid below the window start, gives -1.
   assign avg_offset  = quo_ff - SUM_W'(row_start_ff);
   always_comb begin
      if (use_div_ff && (quo_ff >= SUM_W'(row_start_ff)))
         class_value = avg_offset[CLASS_W:1];
      else
         class_value = CLASS_MISSING;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      col_dark_in  = col_dark_ff;
      missing_in   = missing_ff;
      col_in       = col_ff;
      band_in      = band_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      use_div_in   = use_div_ff;
      pend_band_in = pend_band_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_class_in = rsp_class_ff;
      rsp_band_in  = rsp_band_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_in      = sum_next;
               count_in    = count_next;
               col_dark_in = col_dark_next && !col_close;
               missing_in  = missing_next;
               col_in      = col_close ? col_inc[COL_W-1:0] : col_ff;
               if (band_done) begin
                  quo_in       = sum_next;
                  rem_in       = '0;
                  divisor_in   = count_next;
                  step_in      = '0;
                  use_div_in   = (count_next != '0) && !missing_next;
                  pend_band_in = band_ff;
                  band_in      = band_inc;
                  state_in     = ((count_next != '0) && !missing_next) ? ST_DIV : ST_SEND;
               end
               if (band_done || req_image_end) begin
                  sum_in      = '0;
                  count_in    = '0;
                  col_dark_in = 1'b0;
                  missing_in  = 1'b0;
                  col_in      = '0;
               end
               if (req_image_end) begin
                  band_in = '0;
               end
            end
         end
         ST_DIV: begin
            quo_in  = {quo_ff[SUM_W-2:0], rem_ge};
            rem_in  = rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            step_in = step_ff + DIVCNT_W'(1);
            if (step_ff == DIVCNT_W'(SUM_W - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = class_value;
               rsp_band_in  = pend_band_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         col_dark_ff  <= 1'b0;
         missing_ff   <= 1'b0;
         col_ff       <= '0;
         band_ff      <= '0;
         step_ff      <= '0;
         use_div_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         col_dark_ff  <= col_dark_in;
         missing_ff   <= missing_in;
         col_ff       <= col_in;
         band_ff      <= band_in;
         step_ff      <= step_in;
         use_div_ff   <= use_div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      pend_band_ff <= pend_band_in;
      rsp_class_ff <= rsp_class_in;
      rsp_band_ff  <= rsp_band_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_class_id   = rsp_class_ff;
   assign rsp_band_index = rsp_band_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> divisor_ff != '0)
      else $error("divider running with a zero divisor");

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> step_ff < DIVCNT_W'(SUM_W))
      else $error("divider step count overran");

   a_load_from_send: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_SEND)
      else $error("result word loaded outside the send state");

   a_div_then_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && step_ff == DIVCNT_W'(SUM_W - 1) |=> state_ff == ST_SEND)
      else $error("divider finished without a send");

endmodule : band_dark_centroid_class_unit
`default_nettype wire
